// File: rtl/core/fdlf_pkg.sv
package fdlf_pkg;

	localparam int SAMPLE_W   = 24;
	localparam int GAIN_W     = 16;
	localparam int DELAY_W    = 25;
	localparam int FRAC_W     = 8;
	localparam int WHOLE_W    = DELAY_W - FRAC_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = DELAY_W;
	localparam int DEPTH_DEF  = 131072;

	// register map
	localparam logic [CFG_IDX_W-1:0] REG_DELAY  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FB     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WET    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EXT_FB = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_EXT_IN = 3'd4;

	// unity wet level in Q1.15
	localparam logic [GAIN_W:0] WET_ONE = 17'd32768;

	localparam int SAT_IN_W = 48;
	localparam logic signed [SAT_IN_W-1:0] SAT_HI = (48'sd1 <<< (SAMPLE_W - 1)) - 48'sd1;
	localparam logic signed [SAT_IN_W-1:0] SAT_LO = -SAT_HI - 48'sd1;

	function automatic logic signed [SAMPLE_W-1:0] sat_sample(
		input logic signed [SAT_IN_W-1:0] v
	);
		logic signed [SAT_IN_W-1:0] r;
		r = v;
		if (v > SAT_HI) begin
			r = SAT_HI;
		end else if (v < SAT_LO) begin
			r = SAT_LO;
		end
		return r[SAMPLE_W-1:0];
	endfunction

endpackage

// File: rtl/core/fdlf_whole_mod.sv
module fdlf_whole_mod import fdlf_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      load,
	input  logic [WHOLE_W-1:0]        whole,
	output logic                      busy,
	output logic [$clog2(DEPTH)-1:0]  result
);

	localparam int AW   = $clog2(DEPTH);
	localparam int RW   = ((WHOLE_W > AW) ? WHOLE_W : AW) + 1;
	localparam int KMAX = (WHOLE_W > AW) ? (WHOLE_W - AW) : 0;
	localparam int KW   = (KMAX > 0) ? $clog2(KMAX + 1) : 1;

	logic [RW-1:0] rem_q;
	logic [KW-1:0] k_q;
	logic          busy_q;
	logic [RW-1:0] step_val;

	// restoring reduction, one shifted multiple of the depth per cycle
	assign step_val = RW'(DEPTH) << k_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			k_q    <= '0;
			busy_q <= 1'b0;
		end else if (load) begin
			rem_q  <= RW'(whole);
			k_q    <= KW'(KMAX);
			busy_q <= 1'b1;
		end else if (busy_q) begin
			if (rem_q >= step_val) begin
				rem_q <= rem_q - step_val;
			end
			if (k_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				k_q <= k_q - 1'b1;
			end
		end
	end

	assign busy   = busy_q;
	assign result = rem_q[AW-1:0];

endmodule

// File: rtl/core/fractional_delay_line_feedback.sv
// channel  | handshake          | payload
// ---------+--------------------+-------------------------------------------------
// in       | in_valid/in_ready  | sample_in, external_sample, external_feedback
// out      | out_valid/out_ready| sample_out
// cfg      | cfg_we             | cfg_index, cfg_data
//
// one word at a time, idle, read, interpolate, multiply, write back: the single read
// port of the delay memory fetches the two interpolation taps back to back
// after a delay write, input is held off while the whole part of the delay is reduced
// modulo the depth
// after reset the memory is not swept: a fill mark makes unwritten entries read zero
// a stalled output holds the next word in its last stage; the input stays closed
// until that word moves on
module fractional_delay_line_feedback import fdlf_pkg::*; #(
	parameter int DELAY_DEPTH = DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [SAMPLE_W-1:0]   sample_in,
	input  logic signed [SAMPLE_W-1:0]   external_sample,
	input  logic signed [SAMPLE_W-1:0]   external_feedback,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [SAMPLE_W-1:0]   sample_out,
	input  logic                         cfg_we,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_data
);

	localparam int AW = $clog2(DELAY_DEPTH);
	localparam logic [AW:0]   DEPTH_X = (AW + 1)'(DELAY_DEPTH);
	localparam logic [AW-1:0] LAST    = AW'(DELAY_DEPTH - 1);

	typedef enum logic [2:0] {S_IDLE, S_RDB, S_INT, S_MUL, S_WR} state_t;

	state_t state_q;

	// configuration
	logic [DELAY_W-1:0]       delay_q;
	logic signed [GAIN_W-1:0] fb_gain_q;
	logic [GAIN_W-1:0]        wet_q;
	logic                     ext_fb_q;
	logic                     ext_in_q;

	logic [AW-1:0] wp_q;
	logic          wrapped_q;
	logic          mod_busy;
	logic [AW-1:0] whole_mod;
	logic          mod_load;

	logic signed [SAMPLE_W-1:0] mem_q [DELAY_DEPTH];
	logic signed [SAMPLE_W-1:0] rdata_q;
	logic [AW-1:0]              raddr;
	logic                       mem_we;
	logic signed [SAMPLE_W-1:0] wdata;

	logic [AW:0]   rd_diff;
	logic [AW:0]   rd_wrap;
	logic [AW-1:0] rd;
	logic [AW-1:0] rd1;

	logic signed [SAMPLE_W-1:0]   xin_q;
	logic signed [SAMPLE_W-1:0]   x_q;
	logic signed [SAMPLE_W-1:0]   fbx_q;
	logic [AW-1:0]                rd1_q;
	logic                         a_ok_q;
	logic                         b_ok_q;
	logic                         sub_q;
	logic signed [33:0]           pa_q;
	logic signed [SAMPLE_W-1:0]   d_q;
	logic signed [39:0]           fbp_q;
	logic signed [42:0]           mixp_q;
	logic signed [SAMPLE_W-1:0]   out_q;
	logic                         out_valid_q;

	logic                         accept;
	logic                         out_free;
	logic signed [SAMPLE_W-1:0]   a_mux;
	logic signed [SAMPLE_W-1:0]   b_mux;
	logic [FRAC_W-1:0]            frac;
	logic signed [FRAC_W+1:0]     wfa;
	logic signed [FRAC_W:0]       wfb;
	logic signed [33:0]           interp;
	logic [GAIN_W:0]              wet_c;
	logic signed [GAIN_W+1:0]     wet_s;
	logic signed [SAMPLE_W:0]     dx;
	logic signed [40:0]           fb_round;
	logic signed [26:0]           wr_sum;
	logic signed [43:0]           mix_sum;

	assign mod_load = cfg_we && (cfg_index == REG_DELAY);

	fdlf_whole_mod #(
		.DEPTH(DELAY_DEPTH)
	) u_whole_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (mod_load),
		.whole  (cfg_data[DELAY_W-1:FRAC_W]),
		.busy   (mod_busy),
		.result (whole_mod)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q   <= '0;
			fb_gain_q <= '0;
			wet_q     <= '0;
			ext_fb_q  <= 1'b0;
			ext_in_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DELAY:  delay_q   <= cfg_data[DELAY_W-1:0];
				REG_FB:     fb_gain_q <= cfg_data[GAIN_W-1:0];
				REG_WET:    wet_q     <= cfg_data[GAIN_W-1:0];
				REG_EXT_FB: ext_fb_q  <= cfg_data[0];
				REG_EXT_IN: ext_in_q  <= cfg_data[0];
				default:    ;
			endcase
		end
	end

	// tap addresses, modulo the depth
	assign rd_diff = {1'b0, wp_q} - {1'b0, whole_mod};
	assign rd_wrap = rd_diff + DEPTH_X;
	assign rd      = rd_diff[AW] ? rd_wrap[AW-1:0] : rd_diff[AW-1:0];
	assign rd1     = (rd == '0) ? LAST : rd - 1'b1;

	assign in_ready = (state_q == S_IDLE) && !mod_busy;
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// first tap is read while idle so its data is there on the next cycle
	assign raddr  = (state_q == S_IDLE) ? rd : rd1_q;
	assign mem_we = (state_q == S_WR) && out_free;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[wp_q] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	// interpolation and mix arithmetic
	assign frac  = delay_q[FRAC_W-1:0];
	assign wfa   = $signed({1'b0, 9'd256 - {1'b0, frac}});
	assign wfb   = $signed({1'b0, frac});
	// below one sample the newest tap is the incoming sample itself
	assign a_mux = sub_q ? xin_q : (a_ok_q ? rdata_q : '0);
	assign b_mux = b_ok_q ? rdata_q : '0;
	assign interp = pa_q + (b_mux * wfb) + 34'sd128;

	assign wet_c = ({1'b0, wet_q} > WET_ONE) ? WET_ONE : {1'b0, wet_q};
	assign wet_s = $signed({1'b0, wet_c});
	assign dx    = (SAMPLE_W + 1)'(d_q) - (SAMPLE_W + 1)'(x_q);

	assign fb_round = fbp_q + 41'sd16384;
	assign wr_sum   = ext_fb_q ? (27'(x_q) + 27'(fbx_q))
		: (27'(x_q) + 27'($signed(fb_round[40:15])));
	assign wdata    = sat_sample(SAT_IN_W'(wr_sum));
	// w*d + (1-w)*x folded into w*(d-x) + x
	assign mix_sum  = 44'(mixp_q) + (44'(x_q) <<< 15) + 44'sd16384;

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					xin_q  <= sample_in;
					x_q    <= ext_in_q ? external_sample : sample_in;
					fbx_q  <= external_feedback;
					rd1_q  <= rd1;
					a_ok_q <= wrapped_q || (rd < wp_q);
					b_ok_q <= wrapped_q || (rd1 < wp_q);
					sub_q  <= (delay_q[DELAY_W-1:FRAC_W] == '0);
				end
			end
			S_RDB: begin
				pa_q <= a_mux * wfa;
			end
			S_INT: begin
				d_q <= interp[31:8];
			end
			S_MUL: begin
				fbp_q  <= fb_gain_q * d_q;
				mixp_q <= wet_s * dx;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			wp_q        <= '0;
			wrapped_q   <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && (state_q != S_WR)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_RDB;
					end
				end
				S_RDB: state_q <= S_INT;
				S_INT: state_q <= S_MUL;
				S_MUL: state_q <= S_WR;
				S_WR: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_q       <= sat_sample(SAT_IN_W'($signed(mix_sum[43:15])));
						state_q     <= S_IDLE;
						if (wp_q == LAST) begin
							wp_q      <= '0;
							wrapped_q <= 1'b1;
						end else begin
							wp_q <= wp_q + 1'b1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = out_q;

endmodule

// File: rtl/core/fdlf_checker.sv
module fdlf_checker import fdlf_pkg::*; (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic signed [SAMPLE_W-1:0] sample_out,
	input logic                       cfg_we,
	input logic [CFG_IDX_W-1:0]       cfg_index
);

	// a waiting word is neither dropped nor changed
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sample_out))
		else $error("output word changed or dropped while stalled");

	// an accepted word keeps the input closed through the whole pass
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready ##1 !in_ready ##1 !in_ready ##1 !in_ready)
		else $error("input reopened before the word was written back");

	// a delay write starts the modulo reduction
	a_delay_write_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && (cfg_index == REG_DELAY) |=> !in_ready)
		else $error("input open while the delay is being reduced");

	// no fresh result rises while an accepted word is in the read, interpolate and multiply states
	a_no_spurious_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> ##1 !$rose(out_valid) ##1 !$rose(out_valid)
			##1 !$rose(out_valid))
		else $error("result produced too early");

endmodule

bind fractional_delay_line_feedback fdlf_checker u_fdlf_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.sample_out (sample_out),
	.cfg_we     (cfg_we),
	.cfg_index  (cfg_index)
);

// File: tb/sv/tb.sv
module tb;
	import fdlf_pkg::*;

	localparam int DEPTH = DEPTH_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic signed [SAMPLE_W-1:0] S_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam logic signed [SAMPLE_W-1:0] S_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
	localparam logic signed [SAMPLE_W-1:0] S_ONE = SAMPLE_W'(1);
	localparam logic signed [SAMPLE_W-1:0] S_NEG_ONE = {SAMPLE_W{1'b1}};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [SAMPLE_W-1:0] sample_in = '0;
	logic signed [SAMPLE_W-1:0] external_sample = '0;
	logic signed [SAMPLE_W-1:0] external_feedback = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [SAMPLE_W-1:0] sample_out;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// mirror of the delay line and its registers
	logic signed [SAMPLE_W-1:0] echo_mem [DEPTH];
	int unsigned wr_pos = 0;
	logic [DELAY_W-1:0] delay_reg = '0;
	logic signed [GAIN_W-1:0] fb_reg = '0;
	logic [GAIN_W-1:0] wet_reg = '0;
	logic ext_fb_reg = 1'b0;
	logic ext_in_reg = 1'b0;
	logic signed [SAMPLE_W-1:0] expected_out [$];

	int errors = 0;
	int cycles = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int recv_hold = 0;

	fractional_delay_line_feedback dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic longint round_shift_q(longint v, int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] clip_sample(longint v);
		longint hi, lo;
		hi = (longint'(1) << (SAMPLE_W - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) begin
			v = hi;
		end else if (v < lo) begin
			v = lo;
		end
		return v[SAMPLE_W-1:0];
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] predict_echo(
		logic signed [SAMPLE_W-1:0] xin,
		logic signed [SAMPLE_W-1:0] xext,
		logic signed [SAMPLE_W-1:0] fbext
	);
		int unsigned whole, frac, rd, rd1;
		longint a, b, d, x, wr, w;
		whole = int'(delay_reg[DELAY_W-1:FRAC_W]) % DEPTH;
		frac = 32'(delay_reg[FRAC_W-1:0]);
		rd = (wr_pos >= whole) ? wr_pos - whole : wr_pos + DEPTH - whole;
		rd1 = (rd == 0) ? DEPTH - 1 : rd - 1;
		a = echo_mem[rd];
		b = echo_mem[rd1];
		// below one sample the newest tap is the incoming sample itself
		if (delay_reg[DELAY_W-1:FRAC_W] == 0) begin
			a = xin;
		end
		if (delay_reg == 0) begin
			d = xin;
		end else begin
			d = round_shift_q(a * (256 - longint'(frac)) + b * longint'(frac), FRAC_W);
		end
		if (ext_in_reg) begin
			x = xext;
		end else begin
			x = xin;
		end
		if (ext_fb_reg) begin
			wr = x + fbext;
		end else begin
			wr = x + round_shift_q(longint'(fb_reg) * d, 15);
		end
		echo_mem[wr_pos] = clip_sample(wr);
		wr_pos = (wr_pos + 1) % DEPTH;
		w = 64'(wet_reg);
		if (w > longint'(WET_ONE)) begin
			w = longint'(WET_ONE);
		end
		return clip_sample(round_shift_q(w * d + (longint'(WET_ONE) - w) * x, 15));
	endfunction

	always @(posedge clk) begin
		logic signed [SAMPLE_W-1:0] want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_out.size() == 0) begin
					errors++;
					if (errors <= 20) begin
						$display("%0t: unexpected word %0d", $time, sample_out);
					end
				end else begin
					want = expected_out.pop_front();
					if (want !== sample_out) begin
						errors++;
						if (errors <= 20) begin
							$display("%0t: sample_out expected %0d got %0d",
								$time, want, sample_out);
						end
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_DELAY: delay_reg = cfg_data[DELAY_W-1:0];
					REG_FB: fb_reg = cfg_data[GAIN_W-1:0];
					REG_WET: wet_reg = cfg_data[GAIN_W-1:0];
					REG_EXT_FB: ext_fb_reg = cfg_data[0];
					REG_EXT_IN: ext_in_reg = cfg_data[0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				expected_out.push_back(predict_echo(sample_in, external_sample,
					external_feedback));
			end
		end
	end

	always @(posedge clk) begin
		// long hold-off is counted down here
		if (recv_hold > 0) begin
			out_ready <= 1'b0;
			recv_hold--;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic logic signed [SAMPLE_W-1:0] rand_sample();
		logic [31:0] r;
		r = $urandom();
		case ($urandom_range(0, 7))
			0: return S_MAX;
			1: return S_MIN;
			2: return {{(SAMPLE_W-8){r[7]}}, r[7:0]};
			default: return r[SAMPLE_W-1:0];
		endcase
	endfunction

	function automatic logic [DELAY_W-1:0] rand_delay();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return DELAY_W'($urandom_range(1, 255));
			2, 3: return DELAY_W'($urandom_range(256, 64 * 256));
			4: return DELAY_W'($urandom_range(1, 3) << FRAC_W);
			default: return DELAY_W'($urandom());
		endcase
	endfunction

	function automatic logic [GAIN_W-1:0] rand_gain();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7FFF;
			default: return GAIN_W'($urandom());
		endcase
	endfunction

	function automatic logic [GAIN_W-1:0] rand_wet();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return WET_ONE[GAIN_W-1:0];
			2: return 16'hFFFF;
			default: return GAIN_W'($urandom());
		endcase
	endfunction

	task automatic set_idle(int mode);
		case (mode)
			0: begin send_idle_pct = 0; recv_stall_pct = 0; end
			1: begin send_idle_pct = 59; recv_stall_pct = 0; end
			2: begin send_idle_pct = 0; recv_stall_pct = 59; end
			default: begin send_idle_pct = 36; recv_stall_pct = 36; end
		endcase
	endtask

	task automatic send_word(
		logic signed [SAMPLE_W-1:0] s,
		logic signed [SAMPLE_W-1:0] e,
		logic signed [SAMPLE_W-1:0] f
	);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample_in <= s;
		external_sample <= e;
		external_feedback <= f;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic send_random();
		send_word(rand_sample(), rand_sample(), rand_sample());
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_out.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic load_settings(
		logic [DELAY_W-1:0] delay,
		logic [GAIN_W-1:0] gain,
		logic [GAIN_W-1:0] wet,
		logic ext_fb,
		logic ext_in
	);
		wait_idle();
		write_reg(REG_DELAY, delay);
		write_reg(REG_FB, CFG_DATA_W'(gain));
		write_reg(REG_WET, CFG_DATA_W'(wet));
		write_reg(REG_EXT_FB, CFG_DATA_W'(ext_fb));
		write_reg(REG_EXT_IN, CFG_DATA_W'(ext_in));
		cfg_we <= 1'b0;
	endtask

	task automatic test_reset_state();
		set_idle(0);
		repeat (3) send_random();
	endtask

	task automatic test_corner_cases();
		// zero delay passes sample_in even with the external input selected
		load_settings(25'd0, 16'h8000, 16'h8000, 1'b0, 1'b1);
		send_word(S_MAX, S_MIN, '0);
		send_word(S_MIN, S_MAX, S_MAX);
		send_word('0, S_NEG_ONE, S_MIN);
		// half a sample
		load_settings(25'h80, 16'h7FFF, 16'h4000, 1'b0, 1'b1);
		send_word(S_MAX, '0, '0);
		send_word(S_MIN, S_MAX, '0);
		send_word(S_NEG_ONE, S_MIN, '0);
		// longest delay, wet beyond unity
		load_settings(25'h1FFFFFF, 16'h7FFF, 16'hFFFF, 1'b0, 1'b0);
		send_word(S_MAX, S_MIN, S_MAX);
		send_word(S_MIN, S_MAX, S_MIN);
		send_word(S_ONE, S_NEG_ONE, S_ONE);
		// external feedback, write sum saturates both ways
		load_settings(25'h100, 16'h0000, 16'h8000, 1'b1, 1'b0);
		send_word(S_MAX, '0, S_MAX);
		send_word(S_MIN, '0, S_MIN);
		send_word(S_MAX, '0, S_MIN);
		send_word(S_ONE, '0, S_NEG_ONE);
		load_settings(25'h2FF, 16'hFFFF, 16'h8001, 1'b1, 1'b1);
		repeat (4) send_random();
		// dry only, heavy feedback
		load_settings(25'h300, 16'h7FFF, 16'h0000, 1'b0, 1'b0);
		repeat (3) send_random();
	endtask

	task automatic test_random_settings();
		for (int phase = 0; phase < 16; phase++) begin
			load_settings(rand_delay(), rand_gain(), rand_wet(),
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			set_idle(phase % 4);
			repeat (60) send_random();
		end
	endtask

	task automatic test_backpressure();
		load_settings(25'h380, 16'd20000, 16'd24576, 1'b0, 1'b0);
		set_idle(0);
		recv_hold = 300;
		repeat (40) send_random();
		// sender pauses until every word has come back
		wait_idle();
		repeat (20) send_random();
	endtask

	initial begin
		for (int i = 0; i < DEPTH; i++) begin
			echo_mem[i] = '0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_corner_cases();
		test_random_settings();
		test_backpressure();
		wait_idle();
		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// File: fractional_delay_line_feedback.f
rtl/core/fdlf_pkg.sv
rtl/core/fdlf_whole_mod.sv
rtl/core/fractional_delay_line_feedback.sv
rtl/core/fdlf_checker.sv
tb/sv/tb.sv
